// File: hdl/sobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared constants, types and the 3x3 neighbor tables of the Sobel core.
// ----------------------------------------------------------------------------
package sobm_pkg;

	// Default frame limits.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Field widths.
	localparam int REG_W    = 11;
	localparam int PIX_W    = 8;
	localparam int NUM_CH   = 3;
	localparam int DATA_W   = PIX_W * NUM_CH;
	localparam int NUM_TAPS = 8;
	localparam int TAP_W    = 3;
	localparam int ACC_W    = 11;
	localparam int SQ_W     = 22;

	// Register indexes of the configuration port.
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// Reset value of both dimension registers.
	localparam logic [REG_W-1:0] DIM_RESET = 11'd1024;

	// Largest sum of squares that still rounds below 255.5, and the saturated result.
	localparam logic [SQ_W-1:0]  SAT_SUM = 22'd65280;
	localparam logic [PIX_W-1:0] SAT_VAL = 8'd255;

	// Input item kinds carried on tuser.
	localparam logic MODE_PIXEL = 1'b0;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LAST,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_ROUND,
		ST_EMIT
	} state_t;

	// Neighbor order: above-left, above, above-right, left, right,
	// below-left, below, below-right. The center pixel has weight zero.
	function automatic logic signed [1:0] tap_dr(input logic [TAP_W-1:0] k);
		logic signed [1:0] r;
		unique case (k)
			3'd0, 3'd1, 3'd2: r = -2'sd1;
			3'd3, 3'd4:       r = 2'sd0;
			default:          r = 2'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] tap_dc(input logic [TAP_W-1:0] k);
		logic signed [1:0] r;
		unique case (k)
			3'd0, 3'd3, 3'd5: r = -2'sd1;
			3'd1, 3'd6:       r = 2'sd0;
			default:          r = 2'sd1;
		endcase
		return r;
	endfunction

	// Horizontal kernel weight of a neighbor.
	function automatic logic signed [2:0] tap_cx(input logic [TAP_W-1:0] k);
		logic signed [2:0] r;
		unique case (k)
			3'd0, 3'd5: r = -3'sd1;
			3'd2, 3'd7: r = 3'sd1;
			3'd3:       r = -3'sd2;
			3'd4:       r = 3'sd2;
			default:    r = 3'sd0;
		endcase
		return r;
	endfunction

	// Vertical kernel weight of a neighbor.
	function automatic logic signed [2:0] tap_cy(input logic [TAP_W-1:0] k);
		logic signed [2:0] r;
		unique case (k)
			3'd0, 3'd2: r = -3'sd1;
			3'd5, 3'd7: r = 3'sd1;
			3'd1:       r = -3'sd2;
			3'd6:       r = 3'sd2;
			default:    r = 3'sd0;
		endcase
		return r;
	endfunction

	// Weighted pixel, weights limited to -2..2.
	function automatic logic signed [ACC_W-1:0] weigh(input logic signed [2:0] c,
			input logic [PIX_W-1:0] v);
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] r;
		x = $signed({{(ACC_W-PIX_W){1'b0}}, v});
		unique case (c)
			3'sd1:   r = x;
			-3'sd1:  r = -x;
			3'sd2:   r = x <<< 1;
			-3'sd2:  r = -(x <<< 1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/sobm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sobm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/sobel_edge_magnitude_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude core
// Per-channel 3x3 Sobel gradient magnitude on an RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are kept in a four-row line store (one RAM
// with a single read port). A pixel transaction that releases no result is
// only accepted and checked. A transaction that releases a result also makes
// eight neighbor reads through the one read port, squares both gradients,
// runs an 8-step bit-serial square root and a rounding step, and then outputs.
// Flush transactions (tuser = 1) release the results still pending at frame
// end. A configuration write restarts the frame and drops pending results.
module sobel_edge_magnitude_core
	import sobm_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port.
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [REG_W-1:0]  cfg_data,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // red_in, green_in, blue_in
	input  logic              s_tuser,   // mode
	// Output stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // red_edge, green_edge, blue_edge
	output logic              m_tlast    // frame_end
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CWD = $clog2(MAX_WIDTH + 1);
	localparam int RWD = $clog2(MAX_HEIGHT + 1);
	localparam int AW  = CW + 2;
	localparam int RAM_DEPTH = 4 << CW;

	state_t state_q, state_d;

	logic [REG_W-1:0] reg_w_q, reg_h_q;
	logic [CWD-1:0]   w_eff;
	logic [RWD-1:0]   h_eff;

	logic [RWD-1:0] in_row_q, out_row_q;
	logic [CWD-1:0] in_col_q, out_col_q;
	logic           in_done_q;
	logic           last_q;

	logic [TAP_W-1:0] tap_q;
	logic [TAP_W-1:0] tap_s1;
	logic             rd_en_s1;
	logic             rd_in_s1;

	logic signed [ACC_W-1:0] gx_q [NUM_CH];
	logic signed [ACC_W-1:0] gy_q [NUM_CH];
	logic [SQ_W-1:0]         sq_q [NUM_CH];
	logic [PIX_W-1:0]        root_q [NUM_CH];
	logic [PIX_W-1:0]        res_q [NUM_CH];
	logic [PIX_W-1:0]        bit_q;

	logic              accept;
	logic              ready_c;
	logic              last_c;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              tap_in;
	logic              emit_load;

	// Effective dimensions: zero reads as one, large values saturate.
	always_comb begin
		logic [31:0] wr;
		logic [31:0] hr;
		wr = 32'(reg_w_q);
		hr = 32'(reg_h_q);
		if (wr == 32'd0) w_eff = CWD'(1);
		else if (wr > 32'(MAX_WIDTH)) w_eff = CWD'(MAX_WIDTH);
		else w_eff = CWD'(wr);
		if (hr == 32'd0) h_eff = RWD'(1);
		else if (hr > 32'(MAX_HEIGHT)) h_eff = RWD'(MAX_HEIGHT);
		else h_eff = RWD'(hr);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_w_q <= DIM_RESET;
			reg_h_q <= DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_WIDTH) reg_w_q <= cfg_data;
			if (cfg_index == CFG_IDX_HEIGHT) reg_h_q <= cfg_data;
		end
	end

	assign accept = s_tvalid && s_tready;

	// Line store write for a pixel that belongs to the current frame.
	always_comb begin
		logic [RWD+1:0] row_ext;
		row_ext   = {2'b00, in_row_q};
		ram_we    = accept && (s_tuser == MODE_PIXEL) && !in_done_q;
		ram_waddr = {row_ext[1:0], in_col_q[CW-1:0]};
	end

	// Whether the next result has all its neighbors, and whether it closes the frame.
	always_comb begin
		logic [RWD:0] rp1;
		logic [CWD:0] cp1;
		logic [RWD-1:0] nr;
		logic [CWD-1:0] nc;
		rp1 = {1'b0, out_row_q} + (RWD+1)'(1);
		cp1 = {1'b0, out_col_q} + (CWD+1)'(1);
		nr  = (rp1 < {1'b0, h_eff}) ? rp1[RWD-1:0] : h_eff - RWD'(1);
		nc  = (cp1 < {1'b0, w_eff}) ? cp1[CWD-1:0] : w_eff - CWD'(1);
		ready_c = in_done_q || (nr < in_row_q) || ((nr == in_row_q) && (nc < in_col_q));
		last_c  = (out_row_q == h_eff - RWD'(1)) && (out_col_q == w_eff - CWD'(1));
	end

	// Neighbor address and border mask.
	always_comb begin
		logic signed [RWD:0] rr;
		logic signed [CWD:0] cc;
		logic signed [1:0]   dr, dc;
		dr = tap_dr(tap_q);
		dc = tap_dc(tap_q);
		rr = $signed({1'b0, out_row_q}) + $signed({{(RWD-1){dr[1]}}, dr});
		cc = $signed({1'b0, out_col_q}) + $signed({{(CWD-1){dc[1]}}, dc});
		tap_in = !rr[RWD] && (rr[RWD-1:0] < h_eff) && !cc[CWD] && (cc[CWD-1:0] < w_eff);
		ram_raddr = {rr[1:0], cc[CW-1:0]};
	end

	sobm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_CHECK;
			ST_CHECK: state_d = ready_c ? ST_READ : ST_IDLE;
			ST_READ:  if (tap_q == TAP_W'(NUM_TAPS - 1)) state_d = ST_LAST;
			ST_LAST:  state_d = ST_SQX;
			ST_SQX:   state_d = ST_SQY;
			ST_SQY:   state_d = ST_ROOT;
			ST_ROOT:  if (bit_q[0]) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_EMIT;
			ST_EMIT:  if (emit_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_EMIT: emit_load = !m_tvalid || m_tready;
			default: begin
				s_tready  = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Frame position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_done_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (cfg_we) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_done_q <= 1'b0;
		end else if (ram_we) begin
			if ({1'b0, in_col_q} + (CWD+1)'(1) >= {1'b0, w_eff}) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + RWD'(1);
				if ({1'b0, in_row_q} + (RWD+1)'(1) >= {1'b0, h_eff}) in_done_q <= 1'b1;
			end else begin
				in_col_q <= in_col_q + CWD'(1);
			end
		end else if (state_q == ST_CHECK) begin
			last_q <= last_c;
		end else if (state_q == ST_ROUND) begin
			if (last_q) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				in_done_q <= 1'b0;
			end else if ({1'b0, out_col_q} + (CWD+1)'(1) >= {1'b0, w_eff}) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + RWD'(1);
			end else begin
				out_col_q <= out_col_q + CWD'(1);
			end
		end
	end

	// Neighbor read sequencing; the read data arrives in the cycle after the address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q    <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= (state_q == ST_READ);
			if (state_q == ST_READ) tap_q <= tap_q + TAP_W'(1);
			else tap_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1   <= tap_q;
		rd_in_s1 <= tap_in;
	end

	// Gradient accumulation, squaring, bit-serial root and rounding per channel.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT) bit_q <= bit_q >> 1;
		else bit_q <= 8'h80;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			logic [PIX_W-1:0]   v;
			logic [PIX_W-1:0]   t;
			logic [2*PIX_W-1:0] tt;
			logic [2*PIX_W-1:0] nn;
			logic [SQ_W-1:0]    rem;
			logic signed [2*ACC_W-1:0] p;
			v   = rd_in_s1 ? ram_rdata[ch*PIX_W +: PIX_W] : '0;
			t   = root_q[ch] | bit_q;
			tt  = {8'b0, t} * {8'b0, t};
			nn  = {8'b0, root_q[ch]} * {8'b0, root_q[ch]};
			rem = sq_q[ch] - SQ_W'(nn);
			p   = '0;
			if (state_q == ST_CHECK) begin
				gx_q[ch] <= '0;
				gy_q[ch] <= '0;
			end else if (rd_en_s1) begin
				gx_q[ch] <= gx_q[ch] + weigh(tap_cx(tap_s1), v);
				gy_q[ch] <= gy_q[ch] + weigh(tap_cy(tap_s1), v);
			end
			if (state_q == ST_SQX) begin
				p = gx_q[ch] * gx_q[ch];
				sq_q[ch] <= SQ_W'(p);
			end else if (state_q == ST_SQY) begin
				p = gy_q[ch] * gy_q[ch];
				sq_q[ch] <= sq_q[ch] + SQ_W'(p);
			end
			if (state_q == ST_SQY) begin
				root_q[ch] <= '0;
			end else if (state_q == ST_ROOT) begin
				if (SQ_W'(tt) <= sq_q[ch]) root_q[ch] <= t;
			end
			if (state_q == ST_ROUND) begin
				if (sq_q[ch] > SAT_SUM) res_q[ch] <= SAT_VAL;
				else if ((rem > SQ_W'(root_q[ch])) && (root_q[ch] != SAT_VAL))
					res_q[ch] <= root_q[ch] + PIX_W'(1);
				else res_q[ch] <= root_q[ch];
			end
		end
	end

	// Output register; it holds a result while the next transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_tdata <= {res_q[2], res_q[1], res_q[0]};
			m_tlast <= last_q;
		end
	end

	// Once the frame input is complete, the input row count equals the height.
	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_done_q |-> (in_row_q == h_eff))
		else $error("input done flag disagrees with row count");

	// Results never run ahead of the stored rows.
	a_out_behind: assert property (@(posedge clk) disable iff (!arst_n)
		!in_done_q |-> (out_row_q <= in_row_q))
		else $error("output position ahead of input");

	// A new result only appears from the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result shown outside emit step");

endmodule

// File: dv/sobel_edge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Watches the configuration port and both streams of the Sobel core, predicts
// every edge result from the accepted input transactions and compares each
// output transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sobel_edge_checker
	import sobm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [REG_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic              m_tlast,
	output int                pending_edges,
	output int                fail_count
);

	typedef struct packed {
		logic             frame_end;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} edge_px_t;

	// Four rows of the frame, row r kept in slot r mod 4.
	logic [PIX_W-1:0] rows_mem [4][MAX_WIDTH_DEF][NUM_CH];
	logic [REG_W-1:0] width_reg;
	logic [REG_W-1:0] height_reg;
	int               in_r, in_c, out_r, out_c;
	bit               frame_in_done;
	edge_px_t         edge_queue [$];

	assign pending_edges = edge_queue.size();

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic int clamp_dim(input logic [REG_W-1:0] v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int neighbor(input int r, input int c, input int ch,
			input int h, input int w);
		if (r < 0 || c < 0 || r >= h || c >= w) return 0;
		return rows_mem[r & 3][c][ch];
	endfunction

	// Rounded square root of gx^2 + gy^2, saturated at 255.
	function automatic logic [PIX_W-1:0] grad_mag(input int gx, input int gy);
		int s;
		int n;
		int t;
		s = gx * gx + gy * gy;
		if (s > 65280) return 8'd255;
		n = 0;
		for (int b = 128; b != 0; b = b >> 1) begin
			t = n | b;
			if (t * t <= s) n = t;
		end
		if (s - n * n > n) n++;
		return (n > 255) ? 8'd255 : n[PIX_W-1:0];
	endfunction

	task automatic restart_frame();
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
		frame_in_done = 0;
	endtask

	// Advance the frame state by one input transaction.
	task automatic predict_step(input logic mode, input logic [DATA_W-1:0] px);
		int w;
		int h;
		int nr;
		int nc;
		int a, b, d, e, f, g, k, m;
		int r;
		int c;
		bit ready;
		edge_px_t res;
		w = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		if (mode == MODE_PIXEL && !frame_in_done) begin
			for (int ch = 0; ch < NUM_CH; ch++)
				rows_mem[in_r & 3][in_c][ch] = px[ch*PIX_W +: PIX_W];
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r++;
				if (in_r >= h) frame_in_done = 1;
			end
		end
		nr = (out_r + 1 < h) ? out_r + 1 : h - 1;
		nc = (out_c + 1 < w) ? out_c + 1 : w - 1;
		ready = frame_in_done || nr < in_r || (nr == in_r && nc < in_c);
		if (!ready) return;
		r = out_r;
		c = out_c;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			a = neighbor(r - 1, c - 1, ch, h, w);
			b = neighbor(r - 1, c, ch, h, w);
			d = neighbor(r - 1, c + 1, ch, h, w);
			e = neighbor(r, c - 1, ch, h, w);
			f = neighbor(r, c + 1, ch, h, w);
			g = neighbor(r + 1, c - 1, ch, h, w);
			k = neighbor(r + 1, c, ch, h, w);
			m = neighbor(r + 1, c + 1, ch, h, w);
			case (ch)
				0: res.red   = grad_mag((d + 2*f + m) - (a + 2*e + g),
						(g + 2*k + m) - (a + 2*b + d));
				1: res.green = grad_mag((d + 2*f + m) - (a + 2*e + g),
						(g + 2*k + m) - (a + 2*b + d));
				default: res.blue = grad_mag((d + 2*f + m) - (a + 2*e + g),
						(g + 2*k + m) - (a + 2*b + d));
			endcase
		end
		res.frame_end = (out_r == h - 1) && (out_c == w - 1);
		edge_queue.push_back(res);
		if (res.frame_end) begin
			restart_frame();
		end else begin
			out_c++;
			if (out_c >= w) begin
				out_c = 0;
				out_r++;
			end
		end
	endtask

	// Track configuration writes and both streams at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		edge_px_t want;
		if (!arst_n) begin
			width_reg = DIM_RESET;
			height_reg = DIM_RESET;
			restart_frame();
			edge_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_IDX_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				restart_frame();
			end
			if (s_tvalid && s_tready) predict_step(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (edge_queue.size() == 0) begin
					report("unexpected result transaction", m_tdata, 0);
				end else begin
					want = edge_queue.pop_front();
					if (m_tdata[0 +: PIX_W] !== want.red)
						report("red_edge", m_tdata[0 +: PIX_W], want.red);
					if (m_tdata[PIX_W +: PIX_W] !== want.green)
						report("green_edge", m_tdata[PIX_W +: PIX_W], want.green);
					if (m_tdata[2*PIX_W +: PIX_W] !== want.blue)
						report("blue_edge", m_tdata[2*PIX_W +: PIX_W], want.blue);
					if (m_tlast !== want.frame_end)
						report("frame_end", m_tlast, want.frame_end);
				end
			end
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams directed and random RGB frames of many sizes into the Sobel core
// under varying idle and stall patterns; a checker module predicts and
// compares every edge result.
// ----------------------------------------------------------------------------
module testbench;
	import sobm_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int SETTLE       = 40;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [REG_W-1:0]  cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	int                pending_edges;
	int                fail_count;
	int                tx_idle_pct;
	int                rx_stall_pct;
	bit                hold_toggle;
	bit                hold_seen;
	int                hold_left;
	int                cycles;
	int                random_items;

	sobel_edge_magnitude_core i_dut (.*);

	sobel_edge_checker i_checker (.*);

	always #4 clk = ~clk;

	// Receiver: random stalls plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Cycle budget for the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic mode, input logic [DATA_W-1:0] px);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= px;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
	endtask

	// Stop offering and let every expected result arrive.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_edges == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One frame of random pixels with scattered flushes, then trailing flushes.
	task automatic run_frame(input int npix, input int nflush, input int flush_pct);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(99) < flush_pct) begin
				send_item(~MODE_PIXEL, DATA_W'($urandom));
				random_items++;
			end
			send_item(MODE_PIXEL, DATA_W'($urandom));
			random_items++;
		end
		for (int i = 0; i < nflush; i++) begin
			send_item(~MODE_PIXEL, DATA_W'($urandom));
			random_items++;
		end
	endtask

	initial begin
		int w;
		int h;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IDX_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_PIXEL;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_toggle = 0;
		random_items = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: 3x3 frame with extreme values, flushes with nothing ready
		// and a pixel arriving after the frame input is complete.
		write_reg(CFG_IDX_WIDTH, 11'd3);
		write_reg(CFG_IDX_HEIGHT, 11'd3);
		send_item(~MODE_PIXEL, '1);
		send_item(MODE_PIXEL, 24'hFFFFFF);
		send_item(MODE_PIXEL, 24'h000000);
		send_item(MODE_PIXEL, 24'hFFFFFF);
		send_item(~MODE_PIXEL, '0);
		send_item(MODE_PIXEL, 24'h000000);
		send_item(MODE_PIXEL, 24'hAA55FF);
		send_item(MODE_PIXEL, 24'h55AA00);
		send_item(MODE_PIXEL, 24'hFF00FF);
		send_item(MODE_PIXEL, 24'h00FF00);
		send_item(MODE_PIXEL, 24'hFFFFFF);
		send_item(MODE_PIXEL, 24'h123456);
		for (int i = 0; i < 4; i++) send_item(~MODE_PIXEL, '0);
		drain();
		// Single pixel frame from zero-valued registers.
		write_reg(CFG_IDX_WIDTH, 11'd0);
		write_reg(CFG_IDX_HEIGHT, 11'd0);
		send_item(MODE_PIXEL, 24'hFFFFFF);
		send_item(~MODE_PIXEL, '0);
		drain();

		// Extremes: the start of a long row with a saturated width register,
		// under a long output hold-off so that the core fills and stalls.
		write_reg(CFG_IDX_WIDTH, 11'd2047);
		write_reg(CFG_IDX_HEIGHT, 11'd1);
		@(negedge clk);
		hold_toggle = ~hold_toggle;
		run_frame(120, 3, 0);
		drain();
		// The top of a tall single-pixel column.
		write_reg(CFG_IDX_WIDTH, 11'd1);
		write_reg(CFG_IDX_HEIGHT, 11'd1024);
		run_frame(120, 3, 0);
		drain();
		random_items = 0;

		// Random frames, rotating through the idle patterns.
		for (int fr = 0; random_items < 450; fr++) begin
			case (fr % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
				default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
			endcase
			w = ($urandom_range(7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
			h = $urandom_range(1, 5);
			if (fr % 3 == 0) write_reg(CFG_IDX_WIDTH, REG_W'(w));
			else w = i_checker.width_reg;
			if (fr % 3 != 2) write_reg(CFG_IDX_HEIGHT, REG_W'(h));
			else h = i_checker.height_reg;
			if (w == 0) w = 1;
			if (h == 0) h = 1;
			if (w > 1024) w = 1024;
			if (h > 1024) h = 1024;
			if (fr == 5) begin
				// Long output hold-off while pixels keep coming.
				@(negedge clk);
				hold_toggle = ~hold_toggle;
			end
			if ($urandom_range(9) == 0)
				run_frame($urandom_range(1, w * h), 0, 10);   // broken frame
			else
				run_frame(w * h, w + 2, 10);
			drain();
		end

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		drain();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
